### rtl/assert_macros.svh
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The consequent must hold whenever the antecedent does, in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/jts_pkg.sv
// Types, constants and helper functions for the JSON token scanner.
`timescale 1ns / 1ps

package jts_pkg;

  // Largest document offset that is counted; the offset stops at the smaller cap.
  localparam longint unsigned MAX_DOC_BYTES = 64'd16777215;
  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;
  localparam logic [23:0] OFF_CAP =
    24'((MAX_DOC_BYTES < 64'(CNT_MAX)) ? MAX_DOC_BYTES : 64'(CNT_MAX));

  localparam int unsigned MAX_RESULTS = 3;

  // Characters of interest.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Keywords as they sit right-aligned in the identifier buffer.
  localparam logic [39:0] KW_TRUE  = 40'h0074727565;
  localparam logic [39:0] KW_FALSE = 40'h66616C7365;
  localparam logic [39:0] KW_NULL  = 40'h006E756C6C;

  localparam logic [2:0] ILEN_MAX  = 3'd5;
  localparam logic [2:0] ILEN_LONG = 3'd6;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_IDENT = 3'd1,
    M_STR   = 3'd2,
    M_INT   = 3'd3,
    M_FRAC  = 3'd4,
    M_DOT   = 3'd5,
    M_MINUS = 3'd6
  } mode_t;

  typedef enum logic [3:0] {
    K_LBRACE = 4'd0,
    K_RBRACE = 4'd1,
    K_LBRACK = 4'd2,
    K_RBRACK = 4'd3,
    K_COLON  = 4'd4,
    K_COMMA  = 4'd5,
    K_TRUE   = 4'd6,
    K_FALSE  = 4'd7,
    K_NULL   = 4'd8,
    K_STRING = 4'd9,
    K_NUMBER = 4'd10,
    K_EOF    = 4'd11,
    K_BADID  = 4'd12,
    K_UNTERM = 4'd13,
    K_BADCH  = 4'd14
  } kind_t;

  typedef struct packed {
    mode_t        mode;
    logic [23:0]  tstart;
    logic [23:0]  off;
    logic [23:0]  line;
    logic [23:0]  col;
    logic [39:0]  ibuf;
    logic [2:0]   ilen;   // six means longer than five letters
  } scan_state_t;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   bad_char;
    logic [23:0]  column;
    logic [23:0]  line;
    logic [23:0]  end_offset;
    logic [23:0]  start_offset;
  } result_t;

  typedef struct packed {
    logic [1:0]   cnt;
    result_t [MAX_RESULTS-1:0] slot;
  } result_group_t;

  localparam scan_state_t RESET_STATE = '{
    mode:   M_IDLE,
    tstart: 24'd0,
    off:    24'd0,
    line:   24'd1,
    col:    24'd0,
    ibuf:   40'd0,
    ilen:   3'd0
  };

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Step over one byte: offset and column both move on, each up to its cap.
  function automatic scan_state_t advance(scan_state_t s);
    scan_state_t r;
    r = s;
    if (s.off < OFF_CAP) r.off = s.off + 24'd1;
    if (s.col != CNT_MAX) r.col = s.col + 24'd1;
    return r;
  endfunction

  function automatic kind_t ident_kind(logic [39:0] ibuf, logic [2:0] ilen);
    kind_t k;
    k = K_BADID;
    if ((ilen == 3'd4) && (ibuf == KW_TRUE)) k = K_TRUE;
    else if ((ilen == 3'd5) && (ibuf == KW_FALSE)) k = K_FALSE;
    else if ((ilen == 3'd4) && (ibuf == KW_NULL)) k = K_NULL;
    return k;
  endfunction

  // Append one token, stamped with the current position, to a result group.
  function automatic result_group_t push(result_group_t g, kind_t k, scan_state_t s,
                                         logic [7:0] bad);
    result_group_t r;
    r = g;
    if (g.cnt != 2'd3) begin
      r.slot[g.cnt] = '{kind: k, bad_char: bad, column: s.col, line: s.line,
                        end_offset: s.off, start_offset: s.tstart};
      r.cnt = g.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

### rtl/json_token_scanner_core.sv
// Top level of the streaming JSON token scanner.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Streaming JSON lexer. The slave channel takes one word per document byte
// (tuser low) or an end-of-document word (tuser high, tdata ignored). The
// master channel returns tokens: kind on tuser, positions on tdata, and tlast
// on the final token that a given input word produced. A word may produce no
// token, or up to three (an end word after a held dot gives number, bad dot
// and EOF). Numbers, a leading minus and a dot after digits need the next
// byte to be seen before the token is known, so a number appears one input
// word late.
// An accepted word is held in the input register, its tokens are worked
// out combinationally from it and loaded into the result register, which
// then offers the first token on the master channel.
// Throughput: one input word per cycle while the tokens fit the output; a
// word with n tokens holds the output while they go out one per ready cycle.
// The single result register and its drain rate set that figure.
// When the receiver stalls, the result register holds its token, the input
// register fills and tready drops; words producing no token still pass.
// Reset (synchronous, active high) empties both registers and returns the
// scanner to line one, column zero, offset zero. An end word does the same
// for the scanner state once its tokens are computed.

module json_token_scanner_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] byte_req
  input  logic          s_axis_tuser,   // [0] op
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // [23:0] start_offset, [47:24] end_offset,
                                        // [71:48] line, [95:72] column, [103:96] bad_char
  output logic [3:0]    m_axis_tuser,   // [3:0] kind
  output logic          m_axis_tlast
);

  // Input register: one word waiting to be scanned.
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;

  // Scanner state proper.
  jts_pkg::scan_state_t   st;
  jts_pkg::scan_state_t   st_next;
  jts_pkg::result_group_t grp;

  logic             buf_free;
  logic             consume;
  logic             has_tok;
  jts_pkg::result_t res;

  jts_step u_step (
    .st      (st),
    .op      (in_op),
    .din     (in_byte),
    .st_next (st_next),
    .grp     (grp)
  );

  // A word that yields no token needs no room at the output.
  assign has_tok       = (grp.cnt != 2'd0);
  assign consume       = in_valid && (!has_tok || buf_free);
  assign s_axis_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= jts_pkg::RESET_STATE;
    end else if (consume) begin
      st <= st_next;
    end
  end

  jts_out_buf u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (consume && has_tok),
    .grp_in (grp),
    .free   (buf_free),
    .valid  (m_axis_tvalid),
    .ready  (m_axis_tready),
    .res    (res),
    .last   (m_axis_tlast)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {res.bad_char, res.column, res.line, res.end_offset,
                         res.start_offset};

  `ASSERT_ALWAYS(a_off_capped, clk, rst, (st.off <= jts_pkg::OFF_CAP) && (st.line != 24'd0), "offset or line out of range")
  `ASSERT_IMPLY(a_ident_len, clk, rst, st.mode == jts_pkg::M_IDENT, (st.ilen != 3'd0) && (st.ilen <= jts_pkg::ILEN_LONG), "identifier length lost")
  `ASSERT_NEXT(a_end_resets, clk, rst, consume && in_op, st == jts_pkg::RESET_STATE, "end word left state behind")
  `ASSERT_IMPLY(a_eof_last, clk, rst, m_axis_tvalid && (m_axis_tuser == jts_pkg::K_EOF), m_axis_tlast, "EOF not final token")

endmodule

### rtl/jts_step.sv
// Next-state and token logic for one input word of the scanner.
`timescale 1ns / 1ps

module jts_step (
  input  jts_pkg::scan_state_t   st,
  input  logic                   op,
  input  logic [7:0]             din,
  output jts_pkg::scan_state_t   st_next,
  output jts_pkg::result_group_t grp
);

  always_comb begin
    jts_pkg::scan_state_t   s;
    jts_pkg::result_group_t g;
    logic                   do_idle;
    logic                   dig;
    logic                   let_c;

    s       = st;
    g       = '0;
    do_idle = 1'b0;
    dig     = jts_pkg::is_numeral(din);
    let_c   = jts_pkg::is_letter(din);

    if (op) begin
      // End of document: close any open token, then EOF, then back to reset.
      unique case (s.mode)
        jts_pkg::M_IDENT: g = jts_pkg::push(g, jts_pkg::ident_kind(s.ibuf, s.ilen), s, 8'd0);
        jts_pkg::M_STR:   g = jts_pkg::push(g, jts_pkg::K_UNTERM, s, 8'd0);
        jts_pkg::M_INT,
        jts_pkg::M_FRAC:  g = jts_pkg::push(g, jts_pkg::K_NUMBER, s, 8'd0);
        jts_pkg::M_DOT: begin
          g = jts_pkg::push(g, jts_pkg::K_NUMBER, s, 8'd0);
          s.tstart = s.off;
          s = jts_pkg::advance(s);
          g = jts_pkg::push(g, jts_pkg::K_BADCH, s, jts_pkg::CH_DOT);
        end
        jts_pkg::M_MINUS: begin
          s = jts_pkg::advance(s);
          g = jts_pkg::push(g, jts_pkg::K_BADCH, s, jts_pkg::CH_MINUS);
        end
        default: ;
      endcase
      s.tstart = s.off;
      g = jts_pkg::push(g, jts_pkg::K_EOF, s, 8'd0);
      s = jts_pkg::RESET_STATE;
    end else begin
      unique case (s.mode)
        jts_pkg::M_IDENT: begin
          if (let_c) begin
            s = jts_pkg::advance(s);
            if (s.ilen < jts_pkg::ILEN_MAX) begin
              s.ibuf = {s.ibuf[31:0], din};
              s.ilen = s.ilen + 3'd1;
            end else begin
              s.ilen = jts_pkg::ILEN_LONG;
            end
          end else begin
            g = jts_pkg::push(g, jts_pkg::ident_kind(s.ibuf, s.ilen), s, 8'd0);
            do_idle = 1'b1;
          end
        end
        jts_pkg::M_STR: begin
          s = jts_pkg::advance(s);
          if (din == jts_pkg::CH_QUOTE) begin
            g = jts_pkg::push(g, jts_pkg::K_STRING, s, 8'd0);
            s.mode = jts_pkg::M_IDLE;
          end
        end
        jts_pkg::M_INT: begin
          if (dig) begin
            s = jts_pkg::advance(s);
          end else if (din == jts_pkg::CH_DOT) begin
            s.mode = jts_pkg::M_DOT;
          end else begin
            g = jts_pkg::push(g, jts_pkg::K_NUMBER, s, 8'd0);
            do_idle = 1'b1;
          end
        end
        jts_pkg::M_FRAC: begin
          if (dig) begin
            s = jts_pkg::advance(s);
          end else begin
            g = jts_pkg::push(g, jts_pkg::K_NUMBER, s, 8'd0);
            do_idle = 1'b1;
          end
        end
        jts_pkg::M_DOT: begin
          if (dig) begin
            s = jts_pkg::advance(jts_pkg::advance(s));
            s.mode = jts_pkg::M_FRAC;
          end else begin
            g = jts_pkg::push(g, jts_pkg::K_NUMBER, s, 8'd0);
            s.tstart = s.off;
            s = jts_pkg::advance(s);
            g = jts_pkg::push(g, jts_pkg::K_BADCH, s, jts_pkg::CH_DOT);
            do_idle = 1'b1;
          end
        end
        jts_pkg::M_MINUS: begin
          if (dig) begin
            s = jts_pkg::advance(jts_pkg::advance(s));
            s.mode = jts_pkg::M_INT;
          end else begin
            s = jts_pkg::advance(s);
            g = jts_pkg::push(g, jts_pkg::K_BADCH, s, jts_pkg::CH_MINUS);
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // A byte seen with no token open (or the byte that closed one).
      if (do_idle) begin
        s.mode = jts_pkg::M_IDLE;
        priority if ((din == jts_pkg::CH_SPACE) || (din == jts_pkg::CH_TAB) ||
                     (din == jts_pkg::CH_CR)) begin
          s = jts_pkg::advance(s);
        end else if (din == jts_pkg::CH_LF) begin
          if (s.line != jts_pkg::CNT_MAX) s.line = s.line + 24'd1;
          s.col = 24'd0;
          s = jts_pkg::advance(s);
        end else if (din == jts_pkg::CH_MINUS) begin
          s.tstart = s.off;
          s.mode = jts_pkg::M_MINUS;
        end else begin
          s.tstart = s.off;
          s = jts_pkg::advance(s);
          priority if (let_c) begin
            s.ibuf = {32'd0, din};
            s.ilen = 3'd1;
            s.mode = jts_pkg::M_IDENT;
          end else if (dig) begin
            s.mode = jts_pkg::M_INT;
          end else if (din == jts_pkg::CH_QUOTE) begin
            s.mode = jts_pkg::M_STR;
          end else if (din == jts_pkg::CH_LBRACE) begin
            g = jts_pkg::push(g, jts_pkg::K_LBRACE, s, 8'd0);
          end else if (din == jts_pkg::CH_RBRACE) begin
            g = jts_pkg::push(g, jts_pkg::K_RBRACE, s, 8'd0);
          end else if (din == jts_pkg::CH_LBRACK) begin
            g = jts_pkg::push(g, jts_pkg::K_LBRACK, s, 8'd0);
          end else if (din == jts_pkg::CH_RBRACK) begin
            g = jts_pkg::push(g, jts_pkg::K_RBRACK, s, 8'd0);
          end else if (din == jts_pkg::CH_COLON) begin
            g = jts_pkg::push(g, jts_pkg::K_COLON, s, 8'd0);
          end else if (din == jts_pkg::CH_COMMA) begin
            g = jts_pkg::push(g, jts_pkg::K_COMMA, s, 8'd0);
          end else begin
            g = jts_pkg::push(g, jts_pkg::K_BADCH, s, din);
          end
        end
      end
    end

    st_next = s;
    grp     = g;
  end

endmodule

### rtl/jts_out_buf.sv
// Result register that holds one word's tokens and hands them out one per cycle while ready is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jts_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  jts_pkg::result_group_t grp_in,
  output logic                   free,
  output logic                   valid,
  input  logic                   ready,
  output jts_pkg::result_t       res,
  output logic                   last
);

  jts_pkg::result_t [jts_pkg::MAX_RESULTS-1:0] slot;
  logic [1:0] cnt;
  logic [1:0] idx;

  assign last  = (idx == (cnt - 2'd1));
  assign free  = !valid || (ready && last);
  assign res   = slot[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= 2'd0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      cnt   <= grp_in.cnt;
      idx   <= 2'd0;
    end else if (valid && ready) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= grp_in.slot;
    end
  end

  `ASSERT_IMPLY(a_idx_in_range, clk, rst, valid, (cnt != 2'd0) && (idx < cnt), "token index past count")
  `ASSERT_IMPLY(a_load_when_free, clk, rst, load, free && (grp_in.cnt != 2'd0), "group loaded over live tokens")
  `ASSERT_NEXT(a_hold_on_stall, clk, rst, valid && !ready && !load, valid && $stable(idx), "stalled token moved")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the streaming JSON token scanner.
`timescale 1ns / 1ps

module tb_top;
  import jts_pkg::*;

  // Longest quiet stretch of a correct run is a random sender gap plus a
  // random receiver stall, a few times over; the limit leaves plenty of
  // room on top of that.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_WORDS   = 175;
  localparam int DRAIN_CYCLES   = 8;

  // One expected token, with the fields as the master channel carries them.
  typedef struct {
    kind_t       kind;
    logic [23:0] start_off;
    logic [23:0] end_off;
    logic [23:0] line_no;
    logic [23:0] col_no;
    logic [7:0]  bad;
    logic        last;
  } token_t;

  // One input word: a document byte or an end-of-document marker.
  typedef struct {
    logic       op;
    logic [7:0] value;
  } word_t;

  // The scoreboard carries its own copy of the lexer state and predicts the
  // tokens of every accepted word; results are checked in order of arrival.
  class token_scoreboard;
    mode_t       mode;
    logic [23:0] tok_start;
    logic [23:0] offset;
    logic [23:0] line_no;
    logic [23:0] col_no;
    logic [39:0] letters;
    logic [2:0]  n_letters;
    token_t      burst[$];
    token_t      expected_tokens[$];
    int          mismatches;
    int          tokens_seen;

    function new();
      restart();
      mismatches  = 0;
      tokens_seen = 0;
    endfunction

    function void restart();
      mode      = M_IDLE;
      tok_start = 24'd0;
      offset    = 24'd0;
      line_no   = 24'd1;
      col_no    = 24'd0;
      letters   = 40'd0;
      n_letters = 3'd0;
    endfunction

    function bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void step_byte();
      if (offset < OFF_CAP) offset = offset + 24'd1;
      if (col_no != CNT_MAX) col_no = col_no + 24'd1;
    endfunction

    function void emit_token(kind_t k, logic [7:0] bad);
      token_t t;
      if (burst.size() >= MAX_RESULTS) return;
      t.kind      = k;
      t.start_off = tok_start;
      t.end_off   = offset;
      t.line_no   = line_no;
      t.col_no    = col_no;
      t.bad       = bad;
      t.last      = 1'b0;
      burst.push_back(t);
    endfunction

    // A byte seen with no token open.
    function void plain_byte(logic [7:0] c);
      mode = M_IDLE;
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
        step_byte();
        return;
      end
      if (c == CH_LF) begin
        // The line feed itself counts as the first column of the new line.
        if (line_no != CNT_MAX) line_no = line_no + 24'd1;
        col_no = 24'd0;
        step_byte();
        return;
      end
      tok_start = offset;
      if (c == CH_MINUS) begin
        // Held back: it only belongs to a number if a digit follows.
        mode = M_MINUS;
        return;
      end
      step_byte();
      if (letter(c)) begin
        letters   = {32'd0, c};
        n_letters = 3'd1;
        mode      = M_IDENT;
        return;
      end
      if (digit(c)) begin
        mode = M_INT;
        return;
      end
      case (c)
        CH_QUOTE:  mode = M_STR;
        CH_LBRACE: emit_token(K_LBRACE, 8'h00);
        CH_RBRACE: emit_token(K_RBRACE, 8'h00);
        CH_LBRACK: emit_token(K_LBRACK, 8'h00);
        CH_RBRACK: emit_token(K_RBRACK, 8'h00);
        CH_COLON:  emit_token(K_COLON, 8'h00);
        CH_COMMA:  emit_token(K_COMMA, 8'h00);
        default:   emit_token(K_BADCH, c);
      endcase
    endfunction

    function void close_ident();
      kind_t k;
      k = K_BADID;
      if (n_letters == 3'd4 && letters == KW_TRUE) k = K_TRUE;
      else if (n_letters == 3'd5 && letters == KW_FALSE) k = K_FALSE;
      else if (n_letters == 3'd4 && letters == KW_NULL) k = K_NULL;
      emit_token(k, 8'h00);
    endfunction

    // A held dot with no digit after it: the number ends before the dot.
    function void dot_fail();
      emit_token(K_NUMBER, 8'h00);
      tok_start = offset;
      step_byte();
      emit_token(K_BADCH, CH_DOT);
    endfunction

    function void minus_fail();
      step_byte();
      emit_token(K_BADCH, CH_MINUS);
    endfunction

    function void note_word(logic op, logic [7:0] c);
      burst.delete();
      if (op) begin
        case (mode)
          M_IDENT:        close_ident();
          M_STR:          emit_token(K_UNTERM, 8'h00);
          M_INT, M_FRAC:  emit_token(K_NUMBER, 8'h00);
          M_DOT:          dot_fail();
          M_MINUS:        minus_fail();
          default:        ;
        endcase
        tok_start = offset;
        emit_token(K_EOF, 8'h00);
        restart();
      end else begin
        case (mode)
          M_IDENT: begin
            if (letter(c)) begin
              step_byte();
              if (n_letters < ILEN_MAX) begin
                letters   = {letters[31:0], c};
                n_letters = n_letters + 3'd1;
              end else begin
                n_letters = ILEN_LONG;
              end
            end else begin
              close_ident();
              plain_byte(c);
            end
          end
          M_STR: begin
            step_byte();
            if (c == CH_QUOTE) begin
              emit_token(K_STRING, 8'h00);
              mode = M_IDLE;
            end
          end
          M_INT: begin
            if (digit(c)) step_byte();
            else if (c == CH_DOT) mode = M_DOT;
            else begin
              emit_token(K_NUMBER, 8'h00);
              plain_byte(c);
            end
          end
          M_FRAC: begin
            if (digit(c)) step_byte();
            else begin
              emit_token(K_NUMBER, 8'h00);
              plain_byte(c);
            end
          end
          M_DOT: begin
            if (digit(c)) begin
              step_byte();
              step_byte();
              mode = M_FRAC;
            end else begin
              dot_fail();
              plain_byte(c);
            end
          end
          M_MINUS: begin
            if (digit(c)) begin
              step_byte();
              step_byte();
              mode = M_INT;
            end else begin
              minus_fail();
              plain_byte(c);
            end
          end
          default: plain_byte(c);
        endcase
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) expected_tokens.push_back(burst[i]);
    endfunction

    function void check_token(logic [3:0] kind, logic [103:0] data, logic last);
      token_t want;
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token %0d arrived with none expected: kind %0d data %h last %0b",
                   tokens_seen, kind, data, last);
        return;
      end
      want = expected_tokens.pop_front();
      if (kind !== want.kind || data[23:0] !== want.start_off ||
          data[47:24] !== want.end_off || data[71:48] !== want.line_no ||
          data[95:72] !== want.col_no || data[103:96] !== want.bad ||
          last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("token %0d mismatch (expected / actual):", tokens_seen);
          $display("  kind %0d / %0d  start %0d / %0d  end %0d / %0d",
                   want.kind, kind, want.start_off, data[23:0], want.end_off, data[47:24]);
          $display("  line %0d / %0d  column %0d / %0d  bad %h / %h  last %0b / %0b",
                   want.line_no, data[71:48], want.col_no, data[95:72],
                   want.bad, data[103:96], want.last, last);
        end
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata;
  logic          s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [103:0]  m_axis_tdata;
  logic [3:0]    m_axis_tuser;
  logic          m_axis_tlast;

  token_scoreboard sb;
  word_t           doc_words[$];
  bit              calm;
  int              idle_pct;
  int              quiet_count;

  json_token_scanner_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void add_byte(logic [7:0] b);
    word_t w;
    w.op    = 1'b0;
    w.value = b;
    doc_words.push_back(w);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // The end word carries a byte as well, which the scanner must ignore.
  function automatic void add_end(logic [7:0] junk);
    word_t w;
    w.op    = 1'b1;
    w.value = junk;
    doc_words.push_back(w);
  endfunction

  // Sends every queued word, with random gaps in front of words until the
  // calm point, and hands each accepted word to the scoreboard. The inputs
  // are sampled just after the edge, so they show what the scanner saw.
  task automatic play_queue(input int calm_from);
    for (int i = 0; i < doc_words.size(); i++) begin
      if (i >= calm_from) calm = 1'b1;
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= doc_words[i].value;
      s_axis_tuser  <= doc_words[i].op;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      sb.note_word(doc_words[i].op, doc_words[i].value);
    end
    s_axis_tvalid <= 1'b0;
    doc_words.delete();
  endtask

  // Receiver side: random stall bursts, with stretches of steady readiness,
  // and none at all once the run has gone calm.
  initial begin
    m_axis_tready <= 1'b0;
    quiet_count = 0;
    repeat (4) @(posedge clk);
    forever begin
      @(posedge clk);
      if (calm || quiet_count > 0) begin
        m_axis_tready <= 1'b1;
        if (quiet_count > 0) quiet_count--;
      end else if ($urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 40) == 0) quiet_count = $urandom_range(20, 60);
      end
    end
  end

  // Every token handed over is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_token(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // Watchdog: counts cycles in which neither side moves a word.
  int stuck_cycles;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int         pick;
    logic [7:0] b;
    sb = new();
    calm = 1'b0;
    idle_pct = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed documents: all punctuation, the three keywords, an empty
    // string, a signed fraction, whitespace of every sort, an over-long
    // identifier, a dot and a minus with no digit after them, and the end
    // word arriving with a number, a held dot, a held minus, an identifier
    // and an open string still pending. The extreme byte values go in as
    // unexpected characters.
    add_text("{\"\":-2.5,[true,\tfalse]}\r\nnull");
    add_end(8'hFF);
    add_text("abcdefg 7.-x");
    add_end(8'h00);
    add_text("1.");
    add_end(8'h00);
    add_text("-");
    add_end(8'h00);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("\"a");
    add_end(8'h00);
    add_text("42");
    add_end(8'h00);
    play_queue(doc_words.size() + 1);

    // Random documents built mostly from well-formed tokens with random
    // content, mixed with stray bytes, broken keywords and open strings.
    while (doc_words.size() < RANDOM_WORDS) begin
      pick = $urandom_range(0, 19);
      if (pick <= 3) begin
        case ($urandom_range(0, 5))
          0:       add_byte(CH_LBRACE);
          1:       add_byte(CH_RBRACE);
          2:       add_byte(CH_LBRACK);
          3:       add_byte(CH_RBRACK);
          4:       add_byte(CH_COLON);
          default: add_byte(CH_COMMA);
        endcase
      end else if (pick <= 6) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 1) == 1) add_byte(8'(8'h41 + $urandom_range(0, 25)));
            else add_byte(8'(8'h61 + $urandom_range(0, 25)));
          end
        end else begin
          case ($urandom_range(0, 2))
            0:       add_text("true");
            1:       add_text("false");
            default: add_text("null");
          endcase
        end
        if ($urandom_range(0, 2) != 0) add_byte(CH_COMMA);
      end else if (pick <= 9) begin
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_QUOTE) b = CH_LF;
          add_byte(b);
        end
        if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
      end else if (pick <= 13) begin
        if ($urandom_range(0, 2) == 0) add_byte(CH_MINUS);
        repeat ($urandom_range(1, 4)) add_byte(8'(8'h30 + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
          add_byte(CH_DOT);
          repeat ($urandom_range(0, 3)) add_byte(8'(8'h30 + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) != 0) add_byte(CH_SPACE);
      end else if (pick <= 16) begin
        case ($urandom_range(0, 3))
          0:       add_byte(CH_SPACE);
          1:       add_byte(CH_TAB);
          2:       add_byte(CH_CR);
          default: add_byte(CH_LF);
        endcase
      end else if (pick <= 18) begin
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_end(8'($urandom_range(0, 255)));
      end
    end
    add_end(8'($urandom_range(0, 255)));
    play_queue(doc_words.size() * 85 / 100);

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/jts_pkg.sv
rtl/jts_step.sv
rtl/jts_out_buf.sv
rtl/json_token_scanner_core.sv
tb/tb_top.sv
